FILE: src/chained_hash_map_int_keys_defines.svh
// assertion macros for the chained hash map
`ifndef CHAINED_HASH_MAP_INT_KEYS_DEFINES_SVH
`define CHAINED_HASH_MAP_INT_KEYS_DEFINES_SVH

`ifndef SYNTHESIS
`define CHM_ASSERT(lbl, c, rn, prop, msg) \
  lbl: assert property (@(posedge c) disable iff (!rn) prop) else $error(msg);
`define CHM_ASSERT_ALWAYS(lbl, c, prop, msg) \
  lbl: assert property (@(posedge c) prop) else $error(msg);
`else
`define CHM_ASSERT(lbl, c, rn, prop, msg)
`define CHM_ASSERT_ALWAYS(lbl, c, prop, msg)
`endif

`endif

FILE: src/chm_pkg.sv
// shared constants, codes and hash step for the chained hash map
`timescale 1ns / 1ps
package chm_pkg;
  localparam int BUCKETS_DEF = 256;
  localparam int ENTRIES_DEF = 256;

  localparam logic [63:0] HASH_BASIS = 64'hCBF29CE484222325;
  localparam int          FNV_SHIFT  = 40;
  localparam logic [8:0]  FNV_MUL    = 9'd435;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_POP    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] c);
    logic [63:0] x;
    x = h ^ {56'd0, c};
    return (x << FNV_SHIFT) + x * FNV_MUL;
  endfunction
endpackage

FILE: src/chm_hash.sv
// decimal text fnv-1a hash of a key, reduced modulo the bucket count
`timescale 1ns / 1ps
module chm_hash import chm_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  localparam int CW = $clog2(BUCKETS + 1),
  localparam int BW = $clog2(BUCKETS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   key,
  input  logic [CW-1:0] cnt,
  output logic          done,
  output logic [BW-1:0] bucket
);
  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_DIG  = 2'd1;
  localparam logic [1:0] H_HSH  = 2'd2;
  localparam logic [1:0] H_MOD  = 2'd3;

  logic [1:0]    hs_r, hs_nxt;
  logic [31:0]   mag_r, mag_nxt;
  logic [3:0]    n_r, n_nxt;
  logic [3:0]    dig_r [10];
  logic          dig_we;
  logic [3:0]    dig_wd;
  logic [63:0]   h_r, h_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [5:0]    idx_r, idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [BW-1:0] bucket_r, bucket_nxt;
  logic [63:0]   prod;
  logic [31:0]   q;
  logic [31:0]   r;
  logic [CW:0]   t;

  always_comb begin
    hs_nxt = hs_r;
    mag_nxt = mag_r;
    n_nxt = n_r;
    h_nxt = h_r;
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    bucket_nxt = bucket_r;
    dig_we = 1'b0;
    prod = {32'd0, mag_r} * 64'h00000000CCCCCCCD;
    q = {3'd0, prod[63:35]};
    r = mag_r - ((q << 3) + (q << 1));
    dig_wd = r[3:0];
    t = {rem_r, h_r[idx_r]};
    unique case (hs_r)
      H_IDLE: begin
        if (start) begin
          cnt_nxt = cnt;
          n_nxt = 4'd0;
          if (key[31]) begin
            mag_nxt = 32'd0 - key;
            h_nxt = fnv_step(HASH_BASIS, 8'h2D);
          end else begin
            mag_nxt = key;
            h_nxt = HASH_BASIS;
          end
          hs_nxt = H_DIG;
        end
      end
      H_DIG: begin
        dig_we = 1'b1;
        n_nxt = n_r + 4'd1;
        mag_nxt = q;
        if (q == 32'd0 || n_r == 4'd9) hs_nxt = H_HSH;
      end
      H_HSH: begin
        h_nxt = fnv_step(h_r, {4'h3, dig_r[4'(n_r - 4'd1)]});
        n_nxt = n_r - 4'd1;
        if (n_r == 4'd1) begin
          rem_nxt = '0;
          idx_nxt = 6'd63;
          hs_nxt = H_MOD;
        end
      end
      H_MOD: begin
        if (t >= {1'b0, cnt_r}) rem_nxt = CW'(t - {1'b0, cnt_r});
        else rem_nxt = CW'(t);
        idx_nxt = idx_r - 6'd1;
        if (idx_r == 6'd0) begin
          done_nxt = 1'b1;
          bucket_nxt = BW'(rem_nxt);
          hs_nxt = H_IDLE;
        end
      end
      default: hs_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r <= H_IDLE;
      done_r <= 1'b0;
    end else begin
      hs_r <= hs_nxt;
      done_r <= done_nxt;
    end
    mag_r <= mag_nxt;
    n_r <= n_nxt;
    h_r <= h_nxt;
    rem_r <= rem_nxt;
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    bucket_r <= bucket_nxt;
    if (dig_we) dig_r[n_r] <= dig_wd;
  end

  assign done = done_r;
  assign bucket = bucket_r;
endmodule

FILE: src/chained_hash_map_int_keys.sv
// chained hash map top: request sequencer over bucket, entry and free-stack memories
// insert, lookup and delete hash the key as decimal text, reduce it modulo the bucket
// count bit-serially and walk the bucket's chain; pop scans buckets in order from 0
// one request at a time: in_ready is high only while idle
// reset: a clearing pass empties all buckets and fills the free stack; no request is
// taken until it ends; bucket_count resets to 256
`timescale 1ns / 1ps
module chained_hash_map_int_keys import chm_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_key,
  input  logic [31:0]        in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_key_out,
  output logic [31:0]        out_value_out,
  output logic [8:0]         out_entry_count,
  input  logic               cfg_wr_en,
  input  logic [8:0]         cfg_wr_data
);
  `include "chained_hash_map_int_keys_defines.svh"

  localparam int BW = $clog2(BUCKETS);
  localparam int CW = $clog2(BUCKETS + 1);
  localparam int EW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int XW = (CW > 9) ? CW : 9;
  localparam int CLR_N = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int LW = $clog2(CLR_N);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HASH   = 4'd2;
  localparam logic [3:0] S_BHEAD  = 4'd3;
  localparam logic [3:0] S_ECHK   = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_ALLOC  = 4'd6;
  localparam logic [3:0] S_LINK   = 4'd7;
  localparam logic [3:0] S_SCHK   = 4'd8;
  localparam logic [3:0] S_PREAD  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  typedef struct packed {
    logic          used;
    logic [EW-1:0] head;
  } bkt_t;

  typedef struct packed {
    logic          linked;
    logic [EW-1:0] nxt;
    logic [31:0]   key;
    logic [31:0]   val;
  } ent_t;

  bkt_t          bmem [BUCKETS];
  ent_t          emem [ENTRIES];
  logic [EW-1:0] fmem [ENTRIES];

  bkt_t          b_q, b_wdata;
  logic          b_re, b_we;
  logic [BW-1:0] b_raddr, b_waddr;
  ent_t          e_q, e_wdata;
  logic          e_re, e_we;
  logic [EW-1:0] e_raddr, e_waddr;
  logic [EW-1:0] f_q, f_wdata;
  logic          f_re, f_we;
  logic [EW-1:0] f_raddr, f_waddr;

  logic [3:0]    state_r, state_nxt;
  logic [LW-1:0] clr_r, clr_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [BW-1:0] bkt_r, bkt_nxt;
  logic [BW-1:0] scan_r, scan_nxt;
  logic [EW-1:0] cur_r, cur_nxt;
  logic [EW-1:0] prev_r, prev_nxt;
  logic          has_prev_r, has_prev_nxt;
  logic          found_r, found_nxt;
  logic [EW-1:0] at_r, at_nxt;
  ent_t          at_e_r, at_e_nxt;
  ent_t          pe_r, pe_nxt;
  logic [EW-1:0] new_r, new_nxt;
  logic [FW-1:0] fsp_r, fsp_nxt;
  logic [FW-1:0] count_r, count_nxt;
  logic [8:0]    bcfg_r;
  logic [1:0]    res_st_r, res_st_nxt;
  logic [31:0]   res_key_r, res_key_nxt;
  logic [31:0]   res_val_r, res_val_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_st_r, out_st_nxt;
  logic [31:0]   out_key_r, out_key_nxt;
  logic [31:0]   out_val_r, out_val_nxt;
  logic [8:0]    out_cnt_r, out_cnt_nxt;

  logic          h_start, h_done;
  logic [BW-1:0] h_bucket;
  logic [XW-1:0] bx, bl;
  logic [CW-1:0] cnt_eff;
  logic          in_fire;

  assign bx = XW'(bcfg_r);
  assign bl = (bx == '0) ? XW'(1) : ((bx > XW'(BUCKETS)) ? XW'(BUCKETS) : bx);
  assign cnt_eff = CW'(bl);

  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid && in_ready;

  chm_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (h_start),
    .key    (in_key),
    .cnt    (cnt_eff),
    .done   (h_done),
    .bucket (h_bucket)
  );

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    cmd_nxt = cmd_r;
    key_nxt = key_r;
    val_nxt = val_r;
    bkt_nxt = bkt_r;
    scan_nxt = scan_r;
    cur_nxt = cur_r;
    prev_nxt = prev_r;
    has_prev_nxt = has_prev_r;
    found_nxt = found_r;
    at_nxt = at_r;
    at_e_nxt = at_e_r;
    pe_nxt = pe_r;
    new_nxt = new_r;
    fsp_nxt = fsp_r;
    count_nxt = count_r;
    res_st_nxt = res_st_r;
    res_key_nxt = res_key_r;
    res_val_nxt = res_val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_st_nxt = out_st_r;
    out_key_nxt = out_key_r;
    out_val_nxt = out_val_r;
    out_cnt_nxt = out_cnt_r;
    h_start = 1'b0;
    b_re = 1'b0;
    b_raddr = '0;
    b_we = 1'b0;
    b_waddr = bkt_r;
    b_wdata = '0;
    e_re = 1'b0;
    e_raddr = cur_r;
    e_we = 1'b0;
    e_waddr = at_r;
    e_wdata = '0;
    f_re = 1'b0;
    f_raddr = EW'(fsp_r - FW'(1));
    f_we = 1'b0;
    f_waddr = fsp_r[EW-1:0];
    f_wdata = at_r;

    unique case (state_r)
      S_CLEAR: begin
        if (clr_r < BUCKETS) begin
          b_we = 1'b1;
          b_waddr = clr_r[BW-1:0];
        end
        if (clr_r < ENTRIES) begin
          f_we = 1'b1;
          f_waddr = clr_r[EW-1:0];
          f_wdata = clr_r[EW-1:0];
        end
        clr_nxt = clr_r + LW'(1);
        if (clr_r == LW'(CLR_N - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt = in_command;
          key_nxt = in_key;
          val_nxt = in_value;
          res_st_nxt = ST_OK;
          res_key_nxt = '0;
          res_val_nxt = '0;
          has_prev_nxt = 1'b0;
          found_nxt = 1'b0;
          if (in_command == CMD_POP) begin
            b_re = 1'b1;
            b_raddr = '0;
            bkt_nxt = '0;
            scan_nxt = BW'(1);
            state_nxt = S_SCHK;
          end else begin
            h_start = 1'b1;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (h_done) begin
          b_re = 1'b1;
          b_raddr = h_bucket;
          bkt_nxt = h_bucket;
          state_nxt = S_BHEAD;
        end
      end
      S_BHEAD: begin
        if (b_q.used) begin
          e_re = 1'b1;
          e_raddr = b_q.head;
          cur_nxt = b_q.head;
          state_nxt = S_ECHK;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_ECHK: begin
        if (e_q.key == key_r) begin
          found_nxt = 1'b1;
          at_nxt = cur_r;
          at_e_nxt = e_q;
          state_nxt = S_DECIDE;
        end else begin
          prev_nxt = cur_r;
          pe_nxt = e_q;
          has_prev_nxt = 1'b1;
          if (e_q.linked) begin
            e_re = 1'b1;
            e_raddr = e_q.nxt;
            cur_nxt = e_q.nxt;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        state_nxt = S_OUT;
        case (cmd_r)
          CMD_LOOKUP: begin
            if (found_r) res_val_nxt = at_e_r.val;
            else res_st_nxt = ST_NOTFOUND;
          end
          CMD_INSERT: begin
            if (found_r) begin
              e_we = 1'b1;
              e_waddr = at_r;
              e_wdata = '{linked: at_e_r.linked, nxt: at_e_r.nxt, key: key_r, val: val_r};
            end else if (count_r == FW'(ENTRIES)) begin
              res_st_nxt = ST_FULL;
            end else begin
              f_re = 1'b1;
              state_nxt = S_ALLOC;
            end
          end
          CMD_DELETE: begin
            if (found_r) begin
              if (has_prev_r) begin
                e_we = 1'b1;
                e_waddr = prev_r;
                e_wdata = '{linked: at_e_r.linked, nxt: at_e_r.nxt,
                            key: pe_r.key, val: pe_r.val};
              end else begin
                b_we = 1'b1;
                b_wdata = '{used: at_e_r.linked, head: at_e_r.nxt};
              end
              f_we = 1'b1;
              fsp_nxt = fsp_r + FW'(1);
              count_nxt = count_r - FW'(1);
            end else begin
              res_st_nxt = ST_NOTFOUND;
            end
          end
          default: ;
        endcase
      end
      S_ALLOC: begin
        e_we = 1'b1;
        e_waddr = f_q;
        e_wdata = '{linked: 1'b0, nxt: '0, key: key_r, val: val_r};
        new_nxt = f_q;
        fsp_nxt = fsp_r - FW'(1);
        count_nxt = count_r + FW'(1);
        if (has_prev_r) begin
          state_nxt = S_LINK;
        end else begin
          b_we = 1'b1;
          b_wdata = '{used: 1'b1, head: f_q};
          state_nxt = S_OUT;
        end
      end
      S_LINK: begin
        e_we = 1'b1;
        e_waddr = prev_r;
        e_wdata = '{linked: 1'b1, nxt: new_r, key: pe_r.key, val: pe_r.val};
        state_nxt = S_OUT;
      end
      S_SCHK: begin
        if (b_q.used) begin
          e_re = 1'b1;
          e_raddr = b_q.head;
          at_nxt = b_q.head;
          state_nxt = S_PREAD;
        end else if (bkt_r == BW'(BUCKETS - 1)) begin
          res_st_nxt = ST_EMPTY;
          state_nxt = S_OUT;
        end else begin
          b_re = 1'b1;
          b_raddr = scan_r;
          bkt_nxt = scan_r;
          scan_nxt = scan_r + BW'(1);
        end
      end
      S_PREAD: begin
        res_key_nxt = e_q.key;
        res_val_nxt = e_q.val;
        b_we = 1'b1;
        b_wdata = '{used: e_q.linked, head: e_q.nxt};
        f_we = 1'b1;
        fsp_nxt = fsp_r + FW'(1);
        count_nxt = count_r - FW'(1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt = res_st_r;
          out_key_nxt = res_key_r;
          out_val_nxt = res_val_r;
          out_cnt_nxt = 9'(count_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (b_we) bmem[b_waddr] <= b_wdata;
    if (b_re) b_q <= bmem[b_raddr];
    if (e_we) emem[e_waddr] <= e_wdata;
    if (e_re) e_q <= emem[e_raddr];
    if (f_we) fmem[f_waddr] <= f_wdata;
    if (f_re) f_q <= fmem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      fsp_r <= FW'(ENTRIES);
      count_r <= '0;
      bcfg_r <= 9'd256;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      fsp_r <= fsp_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en) bcfg_r <= cfg_wr_data;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    bkt_r <= bkt_nxt;
    scan_r <= scan_nxt;
    cur_r <= cur_nxt;
    prev_r <= prev_nxt;
    has_prev_r <= has_prev_nxt;
    found_r <= found_nxt;
    at_r <= at_nxt;
    at_e_r <= at_e_nxt;
    pe_r <= pe_nxt;
    new_r <= new_nxt;
    res_st_r <= res_st_nxt;
    res_key_r <= res_key_nxt;
    res_val_r <= res_val_nxt;
    out_st_r <= out_st_nxt;
    out_key_r <= out_key_nxt;
    out_val_r <= out_val_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_status = out_st_r;
  assign out_key_out = out_key_r;
  assign out_value_out = out_val_r;
  assign out_entry_count = out_cnt_r;

  `CHM_ASSERT(a_busy_after_req, clk, rst_n, in_fire |=> !in_ready, "took a request while busy")
  `CHM_ASSERT(a_pool_balance, clk, rst_n,
              (FW + 1)'(fsp_r) + (FW + 1)'(count_r) == (FW + 1)'(ENTRIES),
              "free stack and entry count out of balance")
  `CHM_ASSERT(a_hash_in_wait, clk, rst_n, h_done |-> state_r == S_HASH,
              "hash result arrived outside hash wait")
  `CHM_ASSERT(a_full_no_alloc, clk, rst_n, state_r == S_ALLOC |-> count_r != FW'(ENTRIES),
              "allocation with a full pool")
endmodule

FILE: tb/chained_hash_map_int_keys_tb.sv
// testbench for the chained hash map: directed table, pool-full fill and random requests
`timescale 1ns / 1ps
module chained_hash_map_int_keys_tb import chm_pkg::*; ();

  localparam int NBKT = 256;
  localparam int NENT = 256;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] key_out;
    logic [31:0] value_out;
    logic [8:0]  entry_count;
  } map_reply_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] value;
    bit          typed;
    map_reply_t  reply;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = CMD_LOOKUP;
  logic signed [31:0] in_key = '0;
  logic [31:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [31:0] out_key_out;
  logic [31:0] out_value_out;
  logic [8:0] out_entry_count;
  logic cfg_wr_en = 1'b0;
  logic [8:0] cfg_wr_data = '0;

  // typed reply that rides along with the current request
  bit cur_typed = 0;
  map_reply_t cur_reply = '0;

  map_reply_t replies_due[$];
  int errors = 0;
  int idle_cycles = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_go = 0;
  bit hold_taken = 0;
  int hold_cnt = 0;

  // shadow map state
  bit          bkt_used[NBKT];
  logic [31:0] bkt_head[NBKT];
  logic [31:0] ent_key[NENT];
  logic [31:0] ent_val[NENT];
  bit          ent_linked[NENT];
  logic [31:0] ent_next[NENT];
  logic [31:0] free_stk[NENT];
  int          free_top;
  int          stored;
  logic [8:0]  bkt_count;

  chained_hash_map_int_keys dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_key(in_key), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_key_out(out_key_out),
    .out_value_out(out_value_out), .out_entry_count(out_entry_count),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] key_text_hash(input logic [31:0] k);
    logic [63:0] h;
    logic [31:0] mag;
    logic [7:0] dig[10];
    int n;
    h = 64'hCBF29CE484222325;
    mag = k;
    n = 0;
    if (k[31]) begin
      mag = 32'd0 - k;
      h = (h ^ 64'h2D) * 64'd1099511628211;
    end
    do begin
      dig[n] = 8'h30 + 8'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0 && n < 10);
    while (n > 0) begin
      n--;
      h = (h ^ {56'd0, dig[n]}) * 64'd1099511628211;
    end
    return h;
  endfunction

  function automatic void map_reset();
    for (int i = 0; i < NBKT; i++) begin
      bkt_used[i] = 0;
      bkt_head[i] = 0;
    end
    for (int i = 0; i < NENT; i++) begin
      ent_key[i] = 0;
      ent_val[i] = 0;
      ent_linked[i] = 0;
      ent_next[i] = 0;
      free_stk[i] = NENT - 1 - i;
    end
    free_top = NENT;
    stored = 0;
    bkt_count = NBKT;
  endfunction

  function automatic void release_entry(int b, int at, int prv, bit has_prv);
    if (has_prv) begin
      ent_linked[prv] = ent_linked[at];
      ent_next[prv] = ent_next[at];
    end else begin
      bkt_used[b] = ent_linked[at];
      bkt_head[b] = ent_next[at];
    end
    if (free_top < NENT) free_stk[free_top++] = at;
    if (stored > 0) stored--;
  endfunction

  function automatic map_reply_t map_apply(input logic [1:0] cmd, input logic [31:0] k,
                                           input logic [31:0] v);
    map_reply_t r;
    int cnt, b, cur, at, prv, steps, e;
    bit ok, found, has_prv;
    r = '0;
    if (cmd == CMD_POP) begin
      r.status = ST_EMPTY;
      for (int i = 0; i < NBKT; i++) begin
        if (bkt_used[i]) begin
          at = bkt_head[i] % NENT;
          r.key_out = ent_key[at];
          r.value_out = ent_val[at];
          release_entry(i, at, 0, 0);
          r.status = ST_OK;
          break;
        end
      end
    end else begin
      cnt = bkt_count;
      if (cnt == 0) cnt = 1;
      if (cnt > NBKT) cnt = NBKT;
      b = int'(key_text_hash(k) % 64'(cnt));
      ok = bkt_used[b];
      cur = bkt_head[b] % NENT;
      steps = 0;
      found = 0;
      has_prv = 0;
      prv = 0;
      at = 0;
      while (ok && steps < NENT && !found) begin
        if (ent_key[cur] == k) begin
          found = 1;
          at = cur;
        end else begin
          prv = cur;
          has_prv = 1;
          ok = ent_linked[cur];
          cur = ent_next[cur] % NENT;
          steps++;
        end
      end
      if (cmd == CMD_INSERT) begin
        if (found) ent_val[at] = v;
        else if (free_top == 0) r.status = ST_FULL;
        else begin
          e = free_stk[--free_top] % NENT;
          ent_key[e] = k;
          ent_val[e] = v;
          ent_linked[e] = 0;
          ent_next[e] = 0;
          if (has_prv) begin
            ent_linked[prv] = 1;
            ent_next[prv] = e;
          end else begin
            bkt_used[b] = 1;
            bkt_head[b] = e;
          end
          stored++;
        end
      end else if (cmd == CMD_LOOKUP) begin
        if (found) r.value_out = ent_val[at];
        else r.status = ST_NOTFOUND;
      end else begin
        if (found) release_entry(b, at, prv, has_prv);
        else r.status = ST_NOTFOUND;
      end
    end
    r.entry_count = 9'(stored);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // request side: prediction
  always @(posedge clk) begin
    map_reply_t r;
    if (in_valid && in_ready) begin
      r = map_apply(in_command, in_key, in_value);
      if (cur_typed) begin
        if (r != cur_reply) report_mismatch("directed row", r.value_out, cur_reply.value_out);
        r = cur_reply;
      end
      replies_due.push_back(r);
    end
  end

  // reply side: checking
  always @(posedge clk) begin
    map_reply_t w;
    if (out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected reply", out_value_out, 0);
      end else begin
        w = replies_due.pop_front();
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_key_out !== w.key_out) report_mismatch("key_out", out_key_out, w.key_out);
        if (out_value_out !== w.value_out)
          report_mismatch("value_out", out_value_out, w.value_out);
        if (out_entry_count !== w.entry_count)
          report_mismatch("entry_count", out_entry_count, w.entry_count);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1;
      hold_cnt <= 300;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic [31:0] k,
                              input logic [31:0] v, input bit typed, input map_reply_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_key <= k;
    in_value <= v;
    cur_typed <= typed;
    cur_reply <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send(input logic [1:0] cmd, input logic [31:0] k, input logic [31:0] v);
    send_request(cmd, k, v, 0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_buckets(input logic [8:0] n);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bkt_count = n;
  endtask

  function automatic logic [31:0] pick_key();
    logic [31:0] pool[12] = '{0, 1, -1, 9, 10, -10, 99, 100, 32'h7FFFFFFF, 32'h80000000,
                              1000000000, -999999999};
    case ($urandom_range(3))
      0: return $urandom;
      1: return pool[$urandom_range(11)];
      default: return $urandom_range(40) - 20;
    endcase
  endfunction

  task automatic random_run(input int n, input int w_ins, input int w_look, input int w_del);
    int p;
    logic [1:0] c;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < w_ins) c = CMD_INSERT;
      else if (p < w_ins + w_look) c = CMD_LOOKUP;
      else if (p < w_ins + w_look + w_del) c = CMD_DELETE;
      else c = CMD_POP;
      send(c, pick_key(), $urandom);
    end
  endtask

  dir_row_t dir_rows[$];

  function automatic dir_row_t row(input logic [1:0] c, input logic [31:0] k,
                                   input logic [31:0] v, input bit t, input logic [1:0] s,
                                   input logic [31:0] ko, input logic [31:0] vo,
                                   input int n);
    dir_row_t d;
    d.cmd = c;
    d.key = k;
    d.value = v;
    d.typed = t;
    d.reply = '{s, ko, vo, 9'(n)};
    return d;
  endfunction

  initial begin
    map_reset();
    dir_rows = '{
      row(CMD_POP, 0, 0, 1, ST_EMPTY, 0, 0, 0),
      row(CMD_LOOKUP, 0, 0, 1, ST_NOTFOUND, 0, 0, 0),
      row(CMD_DELETE, -1, 0, 1, ST_NOTFOUND, 0, 0, 0),
      row(CMD_INSERT, 0, 0, 1, ST_OK, 0, 0, 1),
      row(CMD_INSERT, 32'h80000000, 32'hFFFFFFFF, 1, ST_OK, 0, 0, 2),
      row(CMD_INSERT, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, ST_OK, 0, 0, 3),
      row(CMD_LOOKUP, 32'h80000000, 0, 1, ST_OK, 0, 32'hFFFFFFFF, 3),
      row(CMD_INSERT, -1, 5, 1, ST_OK, 0, 0, 4),
      row(CMD_INSERT, 0, 9, 1, ST_OK, 0, 0, 4),
      row(CMD_LOOKUP, 0, 0, 1, ST_OK, 0, 9, 4),
      row(CMD_DELETE, 12345, 0, 1, ST_NOTFOUND, 0, 0, 4),
      row(CMD_DELETE, 32'h7FFFFFFF, 0, 1, ST_OK, 0, 0, 3),
      row(CMD_LOOKUP, 32'h7FFFFFFF, 0, 1, ST_NOTFOUND, 0, 0, 3),
      row(CMD_INSERT, 10, 32'hA5A5A5A5, 0, 0, 0, 0, 0),
      row(CMD_INSERT, 1000000000, 32'h5A5A5A5A, 0, 0, 0, 0, 0),
      row(CMD_INSERT, -1000000000, 1, 0, 0, 0, 0, 0),
      row(CMD_LOOKUP, 1000000000, 0, 0, 0, 0, 0, 0),
      row(CMD_DELETE, -1000000000, 0, 0, 0, 0, 0, 0),
      row(CMD_POP, 0, 0, 0, 0, 0, 0, 0),
      row(CMD_POP, 0, 0, 0, 0, 0, 0, 0),
      row(CMD_POP, 0, 0, 0, 0, 0, 0, 0),
      row(CMD_POP, 0, 0, 0, 0, 0, 0, 0),
      row(CMD_POP, 0, 0, 0, 0, 0, 0, 0),
      row(CMD_POP, 0, 0, 1, ST_EMPTY, 0, 0, 0)
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_request(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].value,
                   dir_rows[i].typed, dir_rows[i].reply);

    // fill the pool through one chain, overflow it, then empty it
    set_buckets(9'd1);
    for (int i = 0; i < NENT; i++) send(CMD_INSERT, i * 7919 - 1000000, $urandom);
    send(CMD_INSERT, 32'h80000000, 1);
    send(CMD_INSERT, 0 * 7919 - 1000000, 2);
    send(CMD_LOOKUP, 255 * 7919 - 1000000, 0);
    for (int i = 0; i <= NENT; i++) send(CMD_POP, $urandom, $urandom);

    set_buckets(9'd0);
    random_run(150, 45, 25, 20);
    // long receiver hold while requests keep coming
    hold_go = 1;
    random_run(100, 40, 25, 20);
    set_buckets(9'd511);
    random_run(200, 40, 25, 20);
    // change the bucket count with entries still stored
    set_buckets(9'd7);
    tx_idle_pct = 61;
    random_run(250, 40, 25, 20);
    set_buckets(9'd256);
    tx_idle_pct = 0;
    rx_stall_pct = 61;
    random_run(250, 40, 25, 20);
    set_buckets(9'd200);
    tx_idle_pct = 10;
    rx_stall_pct = 10;
    random_run(250, 40, 25, 20);
    drain();
    set_buckets(9'd2);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    random_run(250, 30, 25, 15);
    random_run(50, 0, 0, 0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
